// File: rtl/kpbc_pkg.sv
// ---------------------------------------------------------------------------
// kpbc_pkg
// shared types and constants of the keyed packet byte cipher
// ---------------------------------------------------------------------------
package kpbc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int KEY_W       = 8;
    localparam int KEY_ADDR_W  = 8;
    localparam int POS_W       = 6;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CIPHER_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_KEY   = 2'd1;

    // cipher modes (code three behaves as keyed decrypt)
    localparam logic [1:0] MODE_ENCRYPT     = 2'd0;
    localparam logic [1:0] MODE_HDR_DECRYPT = 2'd1;
    localparam logic [1:0] MODE_KEY_DECRYPT = 2'd2;

    // input word kinds
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DATA = 1'b1;

    localparam logic [7:0]       FIRST_XOR   = 8'hAA;
    localparam logic [POS_W-1:0] MASK_BITS   = 6'h24;
    localparam logic [POS_W-1:0] MASK_BASE   = 6'h01;
    localparam logic [7:0]       INVERT_BITS = 8'hFF;

    typedef struct packed {
        logic       action;
        logic [7:0] key_index;
        logic [7:0] key_value;
        logic [7:0] data_byte;
        logic       last_byte;
    } pkt_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } res_word_t;

    // key table access from the front end
    typedef struct packed {
        logic                  we;
        logic [KEY_ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]      wdata;
        logic                  re;
        logic [KEY_ADDR_W-1:0] raddr;
    } ram_req_t;

    // one data byte on its way from the front end to the transform stage
    typedef struct packed {
        logic [7:0]       byte0;
        logic             last0;
        logic [7:0]       byte1;
        logic             last1;
        logic [1:0]       n_words;
        logic             scramble;
        logic             begin_key;
        logic [POS_W-1:0] pos;
        logic             decrypt;
        logic             keyed;
    } stage_item_t;

    typedef struct packed {
        logic one;
        logic two;
    } queue_room_t;

    typedef struct packed {
        logic [1:0] count;
        res_word_t  w0;
        res_word_t  w1;
    } queue_push_t;

endpackage

// File: rtl/keyed_packet_byte_cipher_unit.sv
// ---------------------------------------------------------------------------
// keyed_packet_byte_cipher_unit
// packet byte cipher driven by a 256-byte key table
// ---------------------------------------------------------------------------
// usage:
//   pkt channel: one input word per handshake (valid high, stall low). a word
//     with action load writes key_value into the key table and gives nothing;
//     a data word carries one packet byte and its last flag.
//   res channel: transformed bytes, one word per handshake, with out_last
//     on the final byte of each output packet.
//   cfg channel: valid/ready write of cipher_mode (index 0) or start_key
//     (index 1); ready is always high. write only while the block is idle.
// timing:
//   a data byte is accepted, its key table entry is read into the registered
//   read port at that edge, and the byte is held in the transform stage
//   register, which pushes its words into the result queue once the queue
//   has room for them; res_valid rises once the queue holds a word. one
//   input word per cycle while words out keep pace with bytes in; bytes that
//   give two words (encrypt first byte, header seed and tail) go to the queue.
// reset: mode is header decrypt, start key zero, no packet in progress. the
//   key table is not cleared; load it before sending packets.
// stall: a stalled receiver backs up the result queue; once the transform
//   stage cannot place its words, pkt_stall rises until room frees up.
// ---------------------------------------------------------------------------
module keyed_packet_byte_cipher_unit #(
    parameter int QUEUE_DEPTH = 4   // result queue words, at least 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pkt_valid,
    output logic                                  pkt_stall,
    input  kpbc_pkg::pkt_word_t                   pkt_data,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output kpbc_pkg::res_word_t                   res_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kpbc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [kpbc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import kpbc_pkg::*;

    ram_req_t         ram_req;
    logic [KEY_W-1:0] kv;
    logic             item_valid;
    stage_item_t      item;
    logic             stage_hold;
    queue_room_t      room;
    queue_push_t      push;

    // registers are plain flops, always ready
    assign cfg_ready = 1'b1;

    // packet state, config registers and table addressing
    kpbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_valid  (pkt_valid),
        .pkt_stall  (pkt_stall),
        .pkt_data   (pkt_data),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .stage_hold (stage_hold),
        .ram_req    (ram_req),
        .item_valid (item_valid),
        .item       (item)
    );

    // key table, read data lines up with the transform stage
    kpbc_key_ram u_key_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (kv)
    );

    // add / subtract / xor with the table byte, or invert
    kpbc_transform u_transform (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .kv         (kv),
        .room       (room),
        .stage_hold (stage_hold),
        .push       (push)
    );

    // result words toward the receiver
    kpbc_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

// File: rtl/kpbc_key_ram.sv
// ---------------------------------------------------------------------------
// kpbc_key_ram
// 256 x 8 key table, one write and one registered read port
// ---------------------------------------------------------------------------
module kpbc_key_ram (
    input  logic                                clk,
    input  kpbc_pkg::ram_req_t                  req,
    output logic [kpbc_pkg::KEY_W-1:0]          rdata
);
    import kpbc_pkg::*;

    localparam int DEPTH = 1 << KEY_ADDR_W;

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/kpbc_front.sv
// ---------------------------------------------------------------------------
// kpbc_front
// accepts input words, keeps packet state, issues key table accesses
// ---------------------------------------------------------------------------
module kpbc_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pkt_valid,
    output logic                                   pkt_stall,
    input  kpbc_pkg::pkt_word_t                    pkt_data,
    input  logic                                   cfg_valid,
    input  logic [kpbc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [kpbc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   stage_hold,
    output kpbc_pkg::ram_req_t                     ram_req,
    output logic                                   item_valid,
    output kpbc_pkg::stage_item_t                  item
);
    import kpbc_pkg::*;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_SEED  = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;

    logic [1:0]       mode_reg;
    logic [7:0]       start_key_reg;
    logic [1:0]       phase_reg, phase_next;
    logic             pass_reg, pass_next;
    logic [7:0]       rk_reg, rk_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       held_first_reg, held_first_next;
    logic [7:0]       held_seed_reg, held_seed_next;

    logic       accept;
    logic       data_acc;
    logic       enc, hdr, keyed;
    logic [7:0] b;
    logic       last;
    logic [7:0] f_seed;
    logic [7:0] f_first;
    logic [7:0] seed_sum;
    logic [7:0] raddr;

    assign pkt_stall = stage_hold;
    assign accept    = pkt_valid && !pkt_stall;
    assign data_acc  = accept && (pkt_data.action == ACT_DATA);

    assign enc   = (mode_reg == MODE_ENCRYPT);
    assign hdr   = (mode_reg == MODE_HDR_DECRYPT);
    assign keyed = mode_reg[1];

    assign b        = pkt_data.data_byte;
    assign last     = pkt_data.last_byte;
    assign f_seed   = held_first_reg ^ FIRST_XOR;
    assign f_first  = b ^ FIRST_XOR;
    assign seed_sum = 8'(held_first_reg + b);

    always_comb
    begin
        phase_next      = phase_reg;
        pass_next       = pass_reg;
        rk_next         = rk_reg;
        pos_next        = pos_reg;
        held_first_next = held_first_reg;
        held_seed_next  = held_seed_reg;
        raddr           = rk_reg;

        item           = '0;
        item.byte0     = b;
        item.last0     = last;
        item.byte1     = b;
        item.last1     = last;
        item.n_words   = 2'd1;
        item.pos       = pos_reg;
        item.decrypt   = !enc;
        item.keyed     = keyed;

        unique case (phase_reg)
            PH_SEED:
            begin
                // key comes from first byte plus seed
                raddr          = seed_sum;
                item.begin_key = 1'b1;
                item.byte0     = f_seed;
                item.last0     = 1'b0;
                item.n_words   = (f_seed == 8'd0 || last) ? 2'd2 : 2'd1;
                pass_next      = (f_seed == 8'd0);
                if (f_seed != 8'd0)
                begin
                    held_seed_next = b;
                end
                rk_next    = seed_sum;
                pos_next   = POS_W'(2);
                phase_next = last ? PH_START : PH_BODY;
            end
            PH_BODY:
            begin
                if (!pass_reg)
                begin
                    item.scramble = 1'b1;
                    rk_next       = 8'(rk_reg + 8'd1);
                    pos_next      = POS_W'(pos_reg + POS_W'(1));
                    if (hdr && last)
                    begin
                        // seed byte goes to the tail
                        item.last0   = 1'b0;
                        item.byte1   = held_seed_reg;
                        item.last1   = 1'b1;
                        item.n_words = 2'd2;
                    end
                end
                phase_next = last ? PH_START : PH_BODY;
            end
            default:
            begin
                pass_next = 1'b0;
                if (keyed)
                begin
                    raddr          = start_key_reg;
                    item.begin_key = 1'b1;
                    item.scramble  = 1'b1;
                    item.pos       = '0;
                    rk_next        = 8'(start_key_reg + 8'd1);
                    pos_next       = POS_W'(1);
                    phase_next     = last ? PH_START : PH_BODY;
                end
                else if (last)
                begin
                    // one-byte packet
                    item.last0 = 1'b1;
                    phase_next = PH_START;
                end
                else if (enc)
                begin
                    raddr          = f_first;
                    item.begin_key = 1'b1;
                    item.byte0     = f_first;
                    item.last0     = 1'b0;
                    item.byte1     = 8'd0;
                    item.last1     = 1'b0;
                    item.n_words   = 2'd2;
                    rk_next        = f_first;
                    pos_next       = POS_W'(2);
                    pass_next      = (f_first == 8'd0);
                    phase_next     = PH_BODY;
                end
                else
                begin
                    held_first_next = b;
                    item.n_words    = 2'd0;
                    phase_next      = PH_SEED;
                end
            end
        endcase
    end

    always_comb
    begin
        ram_req.we    = accept && (pkt_data.action == ACT_LOAD);
        ram_req.waddr = pkt_data.key_index;
        ram_req.wdata = pkt_data.key_value;
        ram_req.re    = data_acc;
        ram_req.raddr = raddr;
    end

    assign item_valid = data_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_HDR_DECRYPT;
            start_key_reg  <= '0;
            phase_reg      <= PH_START;
            pass_reg       <= 1'b0;
            rk_reg         <= '0;
            pos_reg        <= '0;
            held_first_reg <= '0;
            held_seed_reg  <= '0;
        end
        else
        begin
            if (data_acc)
            begin
                phase_reg      <= phase_next;
                pass_reg       <= pass_next;
                rk_reg         <= rk_next;
                pos_reg        <= pos_next;
                held_first_reg <= held_first_next;
                held_seed_reg  <= held_seed_next;
            end
            if (cfg_valid && cfg_index == CFG_CIPHER_MODE)
            begin
                // new mode drops any packet in progress
                mode_reg  <= cfg_data[1:0];
                phase_reg <= PH_START;
                pass_reg  <= 1'b0;
            end
            if (cfg_valid && cfg_index == CFG_START_KEY)
            begin
                start_key_reg <= cfg_data[7:0];
            end
        end
    end

endmodule

// File: rtl/kpbc_transform.sv
// ---------------------------------------------------------------------------
// kpbc_transform
// second stage: combines a byte with its table byte and hands words on
// ---------------------------------------------------------------------------
module kpbc_transform (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  kpbc_pkg::stage_item_t             item,
    input  logic [kpbc_pkg::KEY_W-1:0]        kv,
    input  kpbc_pkg::queue_room_t             room,
    output logic                              stage_hold,
    output kpbc_pkg::queue_push_t             push
);
    import kpbc_pkg::*;

    stage_item_t      s1_reg;
    logic             s1_valid_reg;
    logic [POS_W-1:0] mask_reg;

    logic [POS_W-1:0] mask_eff;
    logic             hit, odd, go, fits;
    logic [7:0]       scr;

    assign mask_eff = s1_reg.begin_key ? ((kv[POS_W-1:0] & MASK_BITS) | MASK_BASE) : mask_reg;
    assign odd      = |(s1_reg.pos & mask_eff);
    assign hit      = (|(kv[POS_W-1:0] & mask_eff)) ^ s1_reg.keyed;

    always_comb
    begin
        unique case ({odd, hit})
            2'b11:   scr = s1_reg.decrypt ? 8'(s1_reg.byte0 - kv) : 8'(s1_reg.byte0 + kv);
            2'b10:   scr = s1_reg.byte0 ^ kv;
            2'b01:   scr = s1_reg.decrypt ? 8'(s1_reg.byte0 + kv) : 8'(s1_reg.byte0 - kv);
            default: scr = s1_reg.byte0 ^ INVERT_BITS;
        endcase
    end

    always_comb
    begin
        unique case (s1_reg.n_words)
            2'd0:    fits = 1'b1;
            2'd1:    fits = room.one;
            default: fits = room.two;
        endcase
    end

    assign go         = s1_valid_reg && fits;
    assign stage_hold = s1_valid_reg && !fits;

    always_comb
    begin
        push.count       = go ? s1_reg.n_words : 2'd0;
        push.w0.out_byte = s1_reg.scramble ? scr : s1_reg.byte0;
        push.w0.out_last = s1_reg.last0;
        push.w1.out_byte = s1_reg.byte1;
        push.w1.out_last = s1_reg.last1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            mask_reg     <= MASK_BASE;
        end
        else
        begin
            if (item_valid)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (go && s1_reg.begin_key)
            begin
                mask_reg <= mask_eff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid)
        begin
            s1_reg <= item;
        end
    end

    // a held byte keeps its contents until it moves on
    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        stage_hold |=> s1_valid_reg && $stable(s1_reg))
        else $error("held stage item changed");

    // select mask only ever carries the base bit and the two table bits
    a_mask_shape: assert property (@(posedge clk) disable iff (!rst_n)
        mask_reg[0] && ((mask_reg & ~(MASK_BITS | MASK_BASE)) == '0))
        else $error("select mask out of shape");

endmodule

// File: rtl/kpbc_out_queue.sv
// ---------------------------------------------------------------------------
// kpbc_out_queue
// small result queue, takes up to two words a cycle, gives one unless the receiver stalls
// ---------------------------------------------------------------------------
module kpbc_out_queue #(
    parameter int DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kpbc_pkg::queue_push_t       push,
    output kpbc_pkg::queue_room_t       room,
    output logic                        res_valid,
    input  logic                        res_stall,
    output kpbc_pkg::res_word_t         res_data
);
    import kpbc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_word_t        q_reg [DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr1, wr_ptr2, wr_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + PTR_W'(1));
    endfunction

    assign wr_ptr1 = bump(wr_ptr_reg);
    assign wr_ptr2 = bump(wr_ptr1);

    always_comb
    begin
        unique case (push.count)
            2'd0:    wr_ptr_next = wr_ptr_reg;
            2'd1:    wr_ptr_next = wr_ptr1;
            default: wr_ptr_next = wr_ptr2;
        endcase
    end

    assign res_valid = (cnt_reg != '0);
    assign res_data  = q_reg[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;

    assign room.one = (cnt_reg < CNT_W'(DEPTH));
    assign room.two = (cnt_reg < CNT_W'(DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            cnt_reg <= CNT_W'(cnt_reg + CNT_W'(push.count) - CNT_W'(pop));
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= push.w0;
        end
        if (push.count == 2'd2)
        begin
            q_reg[wr_ptr1] <= push.w1;
        end
    end

    // the stage never pushes more words than there is room for
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> ({1'b0, cnt_reg} + (CNT_W + 1)'(push.count)
            <= (CNT_W + 1)'(DEPTH)))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("result queue count out of range");

endmodule
